FILE: rtl/core/cwr_pkg.sv
// Shared types and codes for the coalesced write ring.
package cwr_pkg;

  localparam int RING_DEPTH = 256;
  localparam int ZONE_SLOTS = 16;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_BATCH  = 2'd1;
  localparam logic [1:0] ST_ZONE_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // one zone as held by a cell
  typedef struct packed {
    logic        valid;
    logic [63:0] base;
    logic [31:0] size;
  } zone_t;

  // true when [inner, inner+ilen) lies within [outer, outer+olen), unwrapped
  function automatic logic range_within(input logic [63:0] inner,
                                        input logic [64:0] ilen,
                                        input logic [63:0] outer,
                                        input logic [31:0] olen);
    logic [63:0] off;
    logic [65:0] endv;
    begin
      off  = inner - outer;
      endv = {2'b00, off} + {1'b0, ilen};
      range_within = (inner >= outer) && (off <= {32'd0, olen}) &&
                     (endv <= {34'd0, olen});
    end
  endfunction

endpackage

FILE: rtl/core/cwr_cell.sv
// One zone cell: holds a zone, matches writes, is refilled from the last zone or cleared on removal.
module cwr_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,      // take zone from add request
  input  cwr_pkg::zone_t load_zone,
  input  logic           replace,   // take zone handed from the last cell
  input  cwr_pkg::zone_t last_zone,
  input  logic           clear,     // drop this zone
  input  logic [63:0]    wr_address,
  input  logic [64:0]    wr_len,
  input  logic [63:0]    rg_address,
  input  logic [31:0]    rg_size,
  output cwr_pkg::zone_t zone,
  output logic           hit,       // write lies inside this zone
  output logic           enclosed   // zone lies inside removal region
);

  // hold the zone
  always_ff @(posedge clk) begin
    if (rst) begin
      zone.valid <= 1'b0;
    end else if (load) begin
      zone <= load_zone;
    end else if (replace) begin
      zone <= last_zone;
    end else if (clear) begin
      zone.valid <= 1'b0;
    end
  end

  // match against the current request
  assign hit      = zone.valid &&
                    cwr_pkg::range_within(wr_address, wr_len, zone.base, zone.size);
  assign enclosed = zone.valid &&
                    cwr_pkg::range_within(zone.base, {33'd0, zone.size}, rg_address, rg_size);

endmodule

FILE: rtl/core/coalesced_write_ring_with_zones.sv
// A request is accepted in IDLE, executes in EXEC and has its result registered in
// OUT; a removal first scans the cell row in SCAN from the last zone down, one zone
// a cycle. A new request is taken only after the last result is registered; a result
// held by m_tready blocks the next request.
// The ring store is a memory with no reset; indexes, zone count, cell valid bits
// and reserve_slots (64) reset synchronously on rst.
module coalesced_write_ring_with_zones (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // tdata: address[63:0], access_len[67:64], write_data[131:68],
  // region_size[163:132], zero pad
  input  logic [167:0]  s_tdata,
  input  logic [1:0]    s_tuser,   // opcode
  output logic          m_tvalid,
  input  logic          m_tready,
  // tdata: entry_address[63:0], entry_len[67:64], entry_data[131:68],
  // zones_in_use[136:132], zero pad
  output logic [143:0]  m_tdata,
  output logic [1:0]    m_tuser,   // status
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data
);

  localparam int RING_DEPTH = cwr_pkg::RING_DEPTH;
  localparam int ZONE_SLOTS = cwr_pkg::ZONE_SLOTS;
  localparam int RW = $clog2(RING_DEPTH);
  localparam int ZW = $clog2(ZONE_SLOTS + 1);
  localparam int IW = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state;
  logic [7:0]  reserve_slots;
  logic [1:0]  op;
  logic [63:0] address;
  logic [3:0]  access_len;
  logic [63:0] write_data;
  logic [31:0] region_size;
  logic [ZW-1:0] zone_count;
  logic [ZW-1:0] scan;
  logic [RW-1:0] write_index, read_index;
  logic [1:0]  status;
  logic        pop_valid;
  logic        res_valid;
  logic [1:0]  res_status;
  logic [ZW-1:0] res_zones;
  logic [131:0] res_entry;

  logic [63:0] ring_addr [RING_DEPTH];
  logic [3:0]  ring_len  [RING_DEPTH];
  logic [63:0] ring_data [RING_DEPTH];
  logic [63:0] rd_addr, rd_data;
  logic [3:0]  rd_len;

  cwr_pkg::zone_t zones [ZONE_SLOTS];
  logic [ZONE_SLOTS-1:0] hit, enclosed, c_load, c_replace, c_clear;
  cwr_pkg::zone_t new_zone, last_zone;

  assign cfg_ready = (state == S_IDLE);
  assign s_tready  = (state == S_IDLE);
  assign new_zone  = '{valid: 1'b1, base: address, size: region_size};
  assign last_zone = zones[IW'(zone_count - ZW'(1))];

  // cell row
  for (genvar g = 0; g < ZONE_SLOTS; g++) begin : g_cell
    cwr_cell u_cell (
      .clk(clk), .rst(rst),
      .load(c_load[g]), .load_zone(new_zone),
      .replace(c_replace[g]), .last_zone(last_zone),
      .clear(c_clear[g]),
      .wr_address(address), .wr_len({61'd0, access_len}),
      .rg_address(address), .rg_size(region_size),
      .zone(zones[g]), .hit(hit[g]), .enclosed(enclosed[g])
    );
  end

  // write acceptance
  logic [RW-1:0] avail;
  logic          wr_ok;
  logic [63:0]   masked;
  assign avail = read_index - write_index - RW'(1);
  assign wr_ok = (access_len <= 4'd8) && (32'(avail) >= 32'(reserve_slots)) && (|hit);
  always_comb begin
    masked = write_data;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) >= access_len) masked[b*8 +: 8] = 8'd0;
    end
  end

  // cell controls: add in EXEC, removal step in SCAN
  logic scan_hit;
  logic [IW-1:0] k;
  assign k = IW'(scan - ZW'(1));
  assign scan_hit = (state == S_SCAN) && (scan != '0) && enclosed[k];
  always_comb begin
    c_load = '0; c_replace = '0; c_clear = '0;
    if (state == S_EXEC && op == cwr_pkg::OP_ADD && zone_count < ZW'(ZONE_SLOTS))
      c_load[IW'(zone_count)] = 1'b1;
    if (scan_hit) begin
      c_clear[IW'(zone_count - ZW'(1))] = 1'b1;
      if (k != IW'(zone_count - ZW'(1))) c_replace[k] = 1'b1;
    end
  end

  // ring memory; capture the head entry while the request executes
  always_ff @(posedge clk) begin
    if (state == S_EXEC && op == cwr_pkg::OP_WRITE && wr_ok) begin
      ring_addr[write_index] <= address;
      ring_len[write_index]  <= access_len;
      ring_data[write_index] <= masked;
    end
    if (state == S_EXEC) begin
      rd_addr <= ring_addr[read_index];
      rd_len  <= ring_len[read_index];
      rd_data <= ring_data[read_index];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; reserve_slots <= 8'd64; zone_count <= '0;
      write_index <= '0; read_index <= '0; res_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) reserve_slots <= cfg_data;
      if (m_tvalid && m_tready && state != S_OUT) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tuser; address <= s_tdata[63:0]; access_len <= s_tdata[67:64];
            write_data <= s_tdata[131:68]; region_size <= s_tdata[163:132];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= cwr_pkg::ST_DONE; pop_valid <= 1'b0; state <= S_OUT;
          case (op)
            cwr_pkg::OP_WRITE: begin
              if (wr_ok) write_index <= write_index + RW'(1);
              else status <= cwr_pkg::ST_NO_BATCH;
            end
            cwr_pkg::OP_ADD: begin
              if (zone_count < ZW'(ZONE_SLOTS)) zone_count <= zone_count + ZW'(1);
              else status <= cwr_pkg::ST_ZONE_FULL;
            end
            cwr_pkg::OP_REMOVE: begin
              scan <= zone_count; state <= S_SCAN;
            end
            default: begin
              if (read_index == write_index) status <= cwr_pkg::ST_EMPTY;
              else begin
                pop_valid <= 1'b1; read_index <= read_index + RW'(1);
              end
            end
          endcase
        end
        S_SCAN: begin
          if (scan == '0) state <= S_OUT;
          else begin
            scan <= scan - ZW'(1);
            if (scan_hit) zone_count <= zone_count - ZW'(1);
          end
        end
        default: begin
          if (!res_valid || (m_tvalid && m_tready)) begin
            res_valid <= 1'b1; res_status <= status; res_zones <= zone_count;
            res_entry[63:0]   <= pop_valid ? rd_addr : 64'd0;
            res_entry[67:64]  <= pop_valid ? rd_len : 4'd0;
            res_entry[131:68] <= pop_valid ? rd_data : 64'd0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign m_tvalid = res_valid;
  assign m_tuser  = res_status;
  assign m_tdata  = {12'(res_zones), res_entry};

endmodule

FILE: rtl/core/cwr_checker.sv
// Port-level checks for the coalesced write ring.
module cwr_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [143:0] m_tdata,
  input logic [1:0]   m_tuser
);
  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");
  // no new request taken in the cycle after one was taken
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted back to back");
  // entry fields are zero on an item whose status is not done
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != cwr_pkg::ST_DONE |-> m_tdata[131:0] == '0)
    else $error("entry fields set on failed item");
  // zone count stays in range
  a_zones: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[136:132] <= 5'(cwr_pkg::ZONE_SLOTS))
    else $error("zone count out of range");
endmodule

bind coalesced_write_ring_with_zones cwr_checker u_cwr_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: test/tb.sv
// Self-checking testbench for the coalesced write ring with address zones.
module tb;

  localparam int RING_DEPTH = 256;
  localparam int ZONE_SLOTS = 16;
  localparam int LIMIT = 400000;

  // one write-ring request as driven on the slave side
  typedef struct {
    logic [1:0]  op;
    logic [63:0] addr;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] rsize;
  } req_t;

  // one response as seen on the master side
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] eaddr;
    logic [3:0]  elen;
    logic [63:0] edata;
    logic [4:0]  zones;
  } rsp_t;

  // directed stimulus row: has_rsp marks a typed-in expected response
  typedef struct {
    req_t req;
    bit   has_rsp;
    rsp_t rsp;
  } row_t;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [167:0]  s_tdata;   // address, access_len, write_data, region_size, pad
  logic [1:0]    s_tuser;   // opcode
  logic          m_tvalid;
  logic          m_tready;
  logic [143:0]  m_tdata;   // entry_address, entry_len, entry_data, zones_in_use, pad
  logic [1:0]    m_tuser;   // status
  logic          cfg_valid;
  logic          cfg_ready;
  logic [7:0]    cfg_data;

  coalesced_write_ring_with_zones u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0]  pr_reserve;
  logic [63:0] pr_zbase [ZONE_SLOTS];
  logic [31:0] pr_zsize [ZONE_SLOTS];
  int          pr_zcount;
  logic [63:0] pr_raddr [RING_DEPTH];
  logic [3:0]  pr_rlen  [RING_DEPTH];
  logic [63:0] pr_rdata [RING_DEPTH];
  int          pr_wr, pr_rd;

  rsp_t expected_rsps [$];
  int   fail_count;
  int   cycle_count;
  bit   no_idle;

  // unwrapped containment of [inner, inner+ilen) in [outer, outer+olen)
  function automatic bit contains(logic [63:0] inner, logic [64:0] ilen,
                                  logic [63:0] outer, logic [31:0] olen);
    logic [65:0] off;
    off = {2'b0, inner} - {2'b0, outer};
    if (inner < outer) return 0;
    return (off + {1'b0, ilen}) <= {34'd0, olen};
  endfunction

  function automatic rsp_t predict_ring(req_t r);
    rsp_t o;
    int   avail;
    bit   hit;
    o = '{default: '0};
    o.status = cwr_pkg::ST_DONE;
    case (r.op)
      cwr_pkg::OP_WRITE: begin
        avail = (pr_rd + RING_DEPTH - pr_wr - 1) % RING_DEPTH;
        hit = 0;
        if (r.len <= 8 && avail >= pr_reserve)
          for (int i = 0; i < pr_zcount; i++)
            if (contains(r.addr, {61'd0, r.len}, pr_zbase[i], pr_zsize[i])) hit = 1;
        if (hit) begin
          pr_raddr[pr_wr] = r.addr;
          pr_rlen[pr_wr]  = r.len;
          pr_rdata[pr_wr] = (r.len >= 8) ? r.data : r.data & ((64'd1 << (r.len * 8)) - 1);
          pr_wr = (pr_wr + 1) % RING_DEPTH;
        end else begin
          o.status = cwr_pkg::ST_NO_BATCH;
        end
      end
      cwr_pkg::OP_ADD: begin
        if (pr_zcount >= ZONE_SLOTS) begin
          o.status = cwr_pkg::ST_ZONE_FULL;
        end else begin
          pr_zbase[pr_zcount] = r.addr;
          pr_zsize[pr_zcount] = r.rsize;
          pr_zcount++;
        end
      end
      cwr_pkg::OP_REMOVE: begin
        for (int k = pr_zcount - 1; k >= 0; k--)
          if (contains(pr_zbase[k], {33'd0, pr_zsize[k]}, r.addr, r.rsize)) begin
            pr_zcount--;
            pr_zbase[k] = pr_zbase[pr_zcount];
            pr_zsize[k] = pr_zsize[pr_zcount];
          end
      end
      default: begin
        if (pr_rd == pr_wr) begin
          o.status = cwr_pkg::ST_EMPTY;
        end else begin
          o.eaddr = pr_raddr[pr_rd];
          o.elen  = pr_rlen[pr_rd];
          o.edata = pr_rdata[pr_rd];
          pr_rd = (pr_rd + 1) % RING_DEPTH;
        end
      end
    endcase
    o.zones = pr_zcount[4:0];
    return o;
  endfunction

  // clock and cycle limit
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // check responses against the oldest expectation
  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      got.eaddr  = m_tdata[63:0];
      got.elen   = m_tdata[67:64];
      got.edata  = m_tdata[131:68];
      got.zones  = m_tdata[136:132];
      if (expected_rsps.size() == 0) begin
        $error("unexpected response status=%0d", got.status);
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.eaddr !== want.eaddr) begin
          $error("entry_address: expected %h actual %h", want.eaddr, got.eaddr);
          fail_count++;
        end
        if (got.elen !== want.elen) begin
          $error("entry_len: expected %0d actual %0d", want.elen, got.elen);
          fail_count++;
        end
        if (got.edata !== want.edata) begin
          $error("entry_data: expected %h actual %h", want.edata, got.edata);
          fail_count++;
        end
        if (got.zones !== want.zones) begin
          $error("zones_in_use: expected %0d actual %0d", want.zones, got.zones);
          fail_count++;
        end
      end
    end
  end

  // receiver stall, driven at the falling edge
  always @(negedge clk) begin
    m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 10);
  end

  // hold the request until taken; the next call or a drain drops valid
  task automatic send_req(req_t r, bit has_rsp, rsp_t typed);
    rsp_t p;
    while (!no_idle && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tuser  <= r.op;
    s_tdata  <= {4'd0, r.rsize, r.data, r.len, r.addr};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    p = predict_ring(r);
    if (has_rsp && p != typed) begin
      $error("directed row disagrees with prediction, status %0d vs %0d",
             typed.status, p.status);
      fail_count++;
    end
    expected_rsps.push_back(p);
    @(negedge clk);
  endtask

  task automatic drain_rsps();
    s_tvalid <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reserve(logic [7:0] v);
    drain_rsps();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    pr_reserve = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t mk(logic [1:0] op, logic [63:0] a, logic [3:0] l,
                              logic [63:0] d, logic [31:0] s);
    req_t r;
    r.op = op; r.addr = a; r.len = l; r.data = d; r.rsize = s;
    return r;
  endfunction

  function automatic rsp_t rs(logic [1:0] st, logic [4:0] z);
    rsp_t o;
    o = '{default: '0};
    o.status = st; o.zones = z;
    return o;
  endfunction

  // random request, mostly aimed at live zones
  function automatic req_t rand_req();
    req_t r;
    int   z;
    int   k;
    r = mk(2'($urandom_range(3)), {$urandom, $urandom}, 4'($urandom_range(15)),
           {$urandom, $urandom}, $urandom);
    k = $urandom_range(99);
    if (k < 50) r.op = cwr_pkg::OP_WRITE;
    else if (k < 62) r.op = cwr_pkg::OP_ADD;
    else if (k < 68) r.op = cwr_pkg::OP_REMOVE;
    else r.op = cwr_pkg::OP_POP;
    if (r.op == cwr_pkg::OP_WRITE && pr_zcount > 0 && $urandom_range(9) < 8) begin
      z = $urandom_range(pr_zcount - 1);
      r.addr = pr_zbase[z] + $urandom_range(pr_zsize[z] < 16 ? 0 : 15);
      if ($urandom_range(9) < 8) r.len = 4'($urandom_range(8));
    end
    if (r.op == cwr_pkg::OP_ADD) begin
      if ($urandom_range(3) != 0) r.rsize = $urandom_range(4096);
      if ($urandom_range(9) == 0) r.addr = 64'hFFFF_FFFF_FFFF_FFF0;
    end
    if (r.op == cwr_pkg::OP_REMOVE && pr_zcount > 0 && $urandom_range(1)) begin
      z = $urandom_range(pr_zcount - 1);
      r.addr = pr_zbase[z] - $urandom_range(8);
      r.rsize = pr_zsize[z] + $urandom_range(16);
    end
    return r;
  endfunction

  row_t rows [$];

  initial begin
    req_t r;
    fail_count = 0; cycle_count = 0; no_idle = 0;
    rst = 1; s_tvalid = 0; s_tdata = '0; s_tuser = '0;
    m_tready = 0; cfg_valid = 0; cfg_data = '0;
    pr_reserve = 8'd64; pr_zcount = 0; pr_wr = 0; pr_rd = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed table: extremes, each opcode and each special case
    rows.push_back('{mk(cwr_pkg::OP_POP, 0, 0, 0, 0), 1, rs(cwr_pkg::ST_EMPTY, 0)});
    rows.push_back('{mk(cwr_pkg::OP_WRITE, 64'h1000, 4, 64'h1122, 0),
                     1, rs(cwr_pkg::ST_NO_BATCH, 0)});
    rows.push_back('{mk(cwr_pkg::OP_ADD, 64'h1000, 0, 0, 32'h100),
                     1, rs(cwr_pkg::ST_DONE, 1)});
    rows.push_back('{mk(cwr_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FF00, 0, 0, 32'hFFFF_FFFF),
                     1, rs(cwr_pkg::ST_DONE, 2)});
    rows.push_back('{mk(cwr_pkg::OP_ADD, 0, 15, 64'hFFFF_FFFF_FFFF_FFFF, 32'h10),
                     1, rs(cwr_pkg::ST_DONE, 3)});
    rows.push_back('{mk(cwr_pkg::OP_WRITE, 64'h1000, 8, 64'hFFFF_FFFF_FFFF_FFFF, 0),
                     0, rs(0, 0)});
    rows.push_back('{mk(cwr_pkg::OP_WRITE, 64'h10FC, 4, 64'hDEAD_BEEF_CAFE_F00D, 0),
                     0, rs(0, 0)});
    rows.push_back('{mk(cwr_pkg::OP_WRITE, 64'h10FD, 4, 64'h1, 0),
                     1, rs(cwr_pkg::ST_NO_BATCH, 3)});
    rows.push_back('{mk(cwr_pkg::OP_WRITE, 64'h1000, 9, 64'h1, 0),
                     1, rs(cwr_pkg::ST_NO_BATCH, 3)});
    rows.push_back('{mk(cwr_pkg::OP_WRITE, 64'h1000, 15, 64'h1, 0),
                     1, rs(cwr_pkg::ST_NO_BATCH, 3)});
    rows.push_back('{mk(cwr_pkg::OP_WRITE, 64'h1010, 0, 64'hFFFF, 0), 0, rs(0, 0)});
    rows.push_back('{mk(cwr_pkg::OP_WRITE, 64'hFFFF_FFFF_FFFF_FFF8, 8, 64'h55, 0),
                     0, rs(0, 0)});
    rows.push_back('{mk(cwr_pkg::OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFC, 8, 64'h55, 0),
                     0, rs(0, 0)});
    rows.push_back('{mk(cwr_pkg::OP_WRITE, 64'h0, 1, 64'hAB, 0), 0, rs(0, 0)});
    rows.push_back('{mk(cwr_pkg::OP_POP, 0, 0, 0, 0), 0, rs(0, 0)});
    rows.push_back('{mk(cwr_pkg::OP_POP, 0, 0, 0, 0), 0, rs(0, 0)});
    for (int i = 0; i < 14; i++)
      rows.push_back('{mk(cwr_pkg::OP_ADD, 64'h8000 + i * 64, 0, 0, 32), 0, rs(0, 0)});
    rows.push_back('{mk(cwr_pkg::OP_REMOVE, 64'h8000, 0, 0, 32'h200), 0, rs(0, 0)});
    rows.push_back('{mk(cwr_pkg::OP_REMOVE, 0, 0, 0, 0), 0, rs(0, 0)});
    rows.push_back('{mk(cwr_pkg::OP_REMOVE, 0, 0, 0, 32'hFFFF_FFFF), 0, rs(0, 0)});
    foreach (rows[i]) send_req(rows[i].req, rows[i].has_rsp, rows[i].rsp);

    // random phases across reserve settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reserve(8'd0);
        1: write_reserve(8'd255);
        2: write_reserve(8'd250);
        3: write_reserve(8'd3);
        default: write_reserve(8'($urandom_range(255)));
      endcase
      no_idle = (ph == 2);
      for (int n = 0; n < 140; n++) begin
        r = rand_req();
        send_req(r, 0, rs(0, 0));
        if (ph == 3 && n == 70) drain_rsps();
      end
    end
    no_idle = 0;

    drain_rsps();
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
